// File: rtl/bgsb_pkg.sv
// ----------------------------------------------------------------------------
// bgsb_pkg
// Types, codes and sizes shared by the bit-granular stream buffer.
// ----------------------------------------------------------------------------
package bgsb_pkg;

  localparam int WORD_W      = 64;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 6;
  localparam int FILL_W      = 7;
  localparam int STORE_WORDS = 64;
  localparam int STORE_AW    = $clog2(STORE_WORDS);
  localparam int STORE_CW    = $clog2(STORE_WORDS + 1);
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  // Command codes on the input channel.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes on the result channel.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLUSH = 2'd1,
    OP_READ  = 2'd2,
    OP_BAD   = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] data_value;
    logic [COUNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status;
  } out_item_t;

  // A classified command as it waits between the front and the back.
  typedef struct packed {
    op_kind_t           op;
    logic [VALUE_W-1:0] data;
    logic [COUNT_W-1:0] count;
  } op_item_t;

  // Low n bits set, for n from 1 to 32.
  function automatic logic [VALUE_W-1:0] low_mask32(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] sh;
    sh = COUNT_W'(VALUE_W) - n;
    return {VALUE_W{1'b1}} >> sh;
  endfunction

endpackage

// File: rtl/bit_granular_stream_buffer_core.sv
// ----------------------------------------------------------------------------
// bit_granular_stream_buffer_core
// MSB-first bit packer and unpacker over 64-bit words joined by a word store.
//
//   channel   ports                           one transfer
//   input     in_push, in_full, in_item       push && !full
//   result    out_empty, out_pop, out_item    pop && !empty
//
// Writes, flushes, ignored commands and reads served from the current drain
// word are carried out as the back engine takes them; a read that needs the
// next store word first waits for the registered read port of the word store
// RAM. Each command is registered in the command queue and its result in the
// result queue before the result shows on the result channel.
// Reset is synchronous and needs no clearing pass; store contents are not
// cleared. in_full rises when four commands wait, and the back engine
// stalls while four results wait.
// ----------------------------------------------------------------------------
module bit_granular_stream_buffer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bgsb_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output bgsb_pkg::out_item_t out_item
);
  import bgsb_pkg::*;

  logic      op_valid;
  op_item_t  op_item;
  logic      op_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  bgsb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op_item  (op_item),
    .op_pop   (op_pop)
  );

  bgsb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_item  (op_item),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  bgsb_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: rtl/bgsb_ram.sv
// ----------------------------------------------------------------------------
// bgsb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bgsb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bgsb_front.sv
// ----------------------------------------------------------------------------
// bgsb_front
// Accepts input transfers, classifies each command and queues it for the back.
// ----------------------------------------------------------------------------
module bgsb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bgsb_pkg::in_item_t  in_item,
  output logic                op_valid,
  output bgsb_pkg::op_item_t  op_item,
  input  logic                op_pop
);
  import bgsb_pkg::*;

  op_item_t         q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wptr_r, wptr_nxt;
  logic [Q_AW-1:0]  rptr_r, rptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  op_item_t         cls;
  logic             count_ok;
  logic             do_push, do_pop;

  assign count_ok = (in_item.bit_count != '0) &&
                    (in_item.bit_count <= COUNT_W'(VALUE_W));

  always_comb begin
    cls.data  = in_item.data_value;
    cls.count = in_item.bit_count;
    unique case (in_item.cmd)
      CMD_WRITE: cls.op = count_ok ? OP_WRITE : OP_BAD;
      CMD_FLUSH: cls.op = OP_FLUSH;
      CMD_READ:  cls.op = count_ok ? OP_READ : OP_BAD;
      default:   cls.op = OP_BAD;
    endcase
  end

  assign in_full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign op_valid = (cnt_r != '0);
  assign op_item  = q_r[rptr_r];
  assign do_push  = in_push && !in_full;
  assign do_pop   = op_pop && op_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

// File: rtl/bgsb_back.sv
// ----------------------------------------------------------------------------
// bgsb_back
// Carries out queued commands: packs bits into the assembly word, drains bits
// from the drain word and keeps the word store between them.
// ----------------------------------------------------------------------------
module bgsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  bgsb_pkg::op_item_t  op_item,
  output logic                op_pop,
  input  logic                res_full,
  output logic                res_push,
  output bgsb_pkg::out_item_t res_item
);
  import bgsb_pkg::*;

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  op_item_t              pend_r, pend_nxt;
  logic [WORD_W-1:0]     asm_word_r, asm_word_nxt;
  logic [FILL_W-1:0]     asm_fill_r, asm_fill_nxt;
  logic [WORD_W-1:0]     drn_word_r, drn_word_nxt;
  logic [FILL_W-1:0]     drn_left_r, drn_left_nxt;
  logic [STORE_AW-1:0]   head_r, head_nxt;
  logic [STORE_AW-1:0]   tail_r, tail_nxt;
  logic [STORE_CW-1:0]   cnt_r, cnt_nxt;

  op_item_t              cur;
  logic [VALUE_W-1:0]    mask;
  logic [VALUE_W-1:0]    wr_val;
  logic [7:0]            wr_sh;
  logic [2*WORD_W-1:0]   wr_win;
  logic [FILL_W-1:0]     wr_sum;
  logic                  push_req;
  logic [WORD_W-1:0]     push_word;
  logic                  store_full;
  logic                  need_pop;
  logic                  have_word;
  logic [WORD_W-1:0]     new_word;
  logic [7:0]            rd_sh;
  logic [2*WORD_W-1:0]   rd_win;
  logic [VALUE_W-1:0]    rd_val;
  logic                  take;
  logic                  defer;
  logic                  exec;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [WORD_W-1:0]     ram_rd_data;

  function automatic logic [STORE_AW-1:0] ptr_inc(input logic [STORE_AW-1:0] p);
    return (p == STORE_AW'(STORE_WORDS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cur  = (state_r == S_WAIT) ? pend_r : op_item;
  assign mask = low_mask32(cur.count);

  // Packing: the value lands in a 128-bit window whose upper half is the
  // assembly word, so a value that crosses the word boundary needs no split.
  assign wr_val = cur.data & mask;
  assign wr_sh  = 8'd128 - {1'b0, asm_fill_r} - {2'b0, cur.count};
  assign wr_win = {asm_word_r, {WORD_W{1'b0}}} |
                  ({{(2*WORD_W-VALUE_W){1'b0}}, wr_val} << wr_sh[6:0]);
  assign wr_sum = asm_fill_r + {1'b0, cur.count};

  assign store_full = (cnt_r == STORE_CW'(STORE_WORDS));
  assign have_word  = (cnt_r != '0);
  assign push_req   = (cur.op == OP_FLUSH) || ((cur.op == OP_WRITE) && wr_sum[6]);
  assign push_word  = (cur.op == OP_FLUSH) ? asm_word_r : wr_win[2*WORD_W-1:WORD_W];

  // Draining: the drain word and the next store word form one window; the
  // shift also equals the bits left after a refill.
  assign need_pop = (drn_left_r < {1'b0, cur.count});
  assign new_word = (state_r == S_WAIT) ? ram_rd_data : '0;
  assign rd_sh    = 8'd64 + {1'b0, drn_left_r} - {2'b0, cur.count};
  assign rd_win   = {drn_word_r, new_word} >> rd_sh[6:0];
  assign rd_val   = rd_win[VALUE_W-1:0] & mask;

  assign take  = (state_r == S_RUN) && op_valid && !res_full;
  assign defer = (cur.op == OP_READ) && need_pop && have_word;
  assign exec  = (take && !defer) || (state_r == S_WAIT);

  assign op_pop    = take;
  assign res_push  = exec;
  assign ram_wr_en = exec && push_req && !store_full;
  assign ram_rd_en = take && defer;

  always_comb begin
    res_item.read_value = (cur.op == OP_READ) ? rd_val : '0;
    if (cur.op == OP_BAD) begin
      res_item.status = ST_IGNORED;
    end else if (push_req && store_full) begin
      res_item.status = ST_DROPPED;
    end else begin
      res_item.status = ST_DONE;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    asm_word_nxt = asm_word_r;
    asm_fill_nxt = asm_fill_r;
    drn_word_nxt = drn_word_r;
    drn_left_nxt = drn_left_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;

    unique case (state_r)
      S_RUN: begin
        if (take && defer) begin
          pend_nxt  = op_item;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_RUN;
        head_nxt  = ptr_inc(head_r);
        cnt_nxt   = cnt_r - 1'b1;
      end
      default: state_nxt = S_RUN;
    endcase

    if (exec) begin
      unique case (cur.op)
        OP_WRITE: begin
          if (wr_sum[6]) begin
            asm_word_nxt = wr_win[WORD_W-1:0];
            asm_fill_nxt = wr_sum - FILL_W'(WORD_W);
          end else begin
            asm_word_nxt = wr_win[2*WORD_W-1:WORD_W];
            asm_fill_nxt = wr_sum;
          end
        end
        OP_FLUSH: begin
          asm_word_nxt = '0;
          asm_fill_nxt = '0;
        end
        OP_READ: begin
          if (need_pop) begin
            drn_word_nxt = new_word;
            drn_left_nxt = rd_sh[FILL_W-1:0];
          end else begin
            drn_left_nxt = drn_left_r - {1'b0, cur.count};
          end
        end
        default: ;
      endcase
      if (ram_wr_en) begin
        tail_nxt = ptr_inc(tail_r);
        cnt_nxt  = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RUN;
      asm_word_r <= '0;
      asm_fill_r <= '0;
      drn_word_r <= '0;
      drn_left_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      asm_word_r <= asm_word_nxt;
      asm_fill_r <= asm_fill_nxt;
      drn_word_r <= drn_word_nxt;
      drn_left_r <= drn_left_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  bgsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (push_word),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

endmodule

// File: rtl/bgsb_res_q.sv
// ----------------------------------------------------------------------------
// bgsb_res_q
// Result queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module bgsb_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  bgsb_pkg::out_item_t res_item,
  output logic                res_full,
  output logic                out_empty,
  input  logic                out_pop,
  output bgsb_pkg::out_item_t out_item
);
  import bgsb_pkg::*;

  out_item_t        q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wptr_r, wptr_nxt;
  logic [Q_AW-1:0]  rptr_r, rptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign res_full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_item  = q_r[rptr_r];
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= res_item;
    end
  end

endmodule

// File: rtl/bgsb_checker.sv
// ----------------------------------------------------------------------------
// bgsb_checker
// Port-level checks of the stream buffer, bound to the top level.
// ----------------------------------------------------------------------------
module bgsb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input bgsb_pkg::in_item_t  in_item,
  input logic                out_empty,
  input logic                out_pop,
  input bgsb_pkg::out_item_t out_item
);
  import bgsb_pkg::*;

  logic [4:0] pending_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_push && !in_full;
  assign out_xfer = out_pop && !out_empty;

  // Items accepted whose results have not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 5'(in_xfer) - 5'(out_xfer);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == '0 |-> out_empty)
    else $error("result shown with no outstanding item");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.status != ST_DONE |-> out_item.read_value == '0)
    else $error("nonzero read value on a failed command");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed before transfer");

endmodule

bind bit_granular_stream_buffer_core bgsb_checker u_bgsb_checker (.*);

// File: dv/bit_granular_stream_buffer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_granular_stream_buffer_core_tb
// Drives write, flush and read commands into the bit buffer under several
// patterns of input gaps and output stalls. A behavioral copy of the packer,
// word store and unpacker predicts every result, and each result transfer is
// compared against the oldest prediction.
// ----------------------------------------------------------------------------
module bit_granular_stream_buffer_core_tb;
  import bgsb_pkg::*;

  localparam logic [1:0] CMD_UNDEF   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 20;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  bit_granular_stream_buffer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Behavioral state of the packer, the word store and the unpacker.
  logic [WORD_W-1:0] asm_word;
  int                asm_fill;
  logic [WORD_W-1:0] drain_word;
  int                drain_left;
  logic [WORD_W-1:0] word_mem [STORE_WORDS];
  int                mem_head;
  int                mem_tail;
  int                mem_count;

  out_item_t stream_results_q[$];
  out_item_t oldest_result;
  int        error_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        pop_hold_req;
  int        pop_hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] ones(input int n);
    return (64'd1 << n) - 64'd1;
  endfunction

  // Stores the assembly word (dropped when the store is full) and clears it.
  function automatic bit close_assembly();
    bit stored;
    stored = (mem_count < STORE_WORDS);
    if (stored) begin
      word_mem[mem_tail] = asm_word;
      mem_tail = (mem_tail + 1) % STORE_WORDS;
      mem_count++;
    end
    asm_word = '0;
    asm_fill = 0;
    return stored;
  endfunction

  // An empty store hands out a zero word.
  function automatic logic [WORD_W-1:0] fetch_word();
    logic [WORD_W-1:0] w;
    w = '0;
    if (mem_count != 0) begin
      w = word_mem[mem_head];
      mem_head = (mem_head + 1) % STORE_WORDS;
      mem_count--;
    end
    return w;
  endfunction

  function automatic out_item_t buffer_step(input in_item_t it);
    out_item_t         res;
    logic [WORD_W-1:0] v;
    int                n;
    int                room;
    int                rest;
    bit                count_ok;
    n = int'(it.bit_count);
    count_ok = (n >= 1 && n <= VALUE_W);
    res.read_value = '0;
    res.status = ST_DONE;
    case (it.cmd)
      CMD_WRITE: begin
        if (!count_ok) begin
          res.status = ST_IGNORED;
        end else begin
          v = WORD_W'(it.data_value) & ones(n);
          room = WORD_W - asm_fill;
          if (room >= n) begin
            asm_word |= v << (room - n);
            asm_fill += n;
            if (asm_fill == WORD_W && !close_assembly()) res.status = ST_DROPPED;
          end else begin
            // The value straddles two words: the high part closes this one.
            rest = n - room;
            asm_word |= v >> rest;
            if (!close_assembly()) res.status = ST_DROPPED;
            asm_word = (v & ones(rest)) << (WORD_W - rest);
            asm_fill = rest;
          end
        end
      end
      CMD_FLUSH: begin
        if (!close_assembly()) res.status = ST_DROPPED;
      end
      CMD_READ: begin
        if (!count_ok) begin
          res.status = ST_IGNORED;
        end else begin
          if (drain_left == 0) begin
            drain_word = fetch_word();
            drain_left = WORD_W;
          end
          if (drain_left >= n) begin
            v = (drain_word >> (drain_left - n)) & ones(n);
            drain_left -= n;
          end else begin
            rest = n - drain_left;
            v = drain_word & ones(drain_left);
            drain_word = fetch_word();
            v = (v << rest) | ((drain_word >> (WORD_W - rest)) & ones(rest));
            drain_left = WORD_W - rest;
          end
          res.read_value = v[VALUE_W-1:0];
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] cmd,
                                        input logic [VALUE_W-1:0] data,
                                        input logic [COUNT_W-1:0] count);
    in_item_t it;
    it.cmd = cmd;
    it.data_value = data;
    it.bit_count = count;
    return it;
  endfunction

  // Mostly valid writes and reads, with a few flushes, bad counts and
  // undefined commands mixed in.
  function automatic in_item_t random_cmd(input int write_pct);
    in_item_t it;
    int       pick;
    int       sel;
    pick = $urandom_range(99);
    sel = $urandom_range(99);
    if (pick < 3) it.cmd = CMD_UNDEF;
    else if (pick < 7) it.cmd = CMD_FLUSH;
    else if (pick < 7 + write_pct * 93 / 100) it.cmd = CMD_WRITE;
    else it.cmd = CMD_READ;
    it.data_value = $urandom;
    if (sel < 8) it.bit_count = COUNT_W'($urandom_range(63));
    else if (sel < 16) it.bit_count = COUNT_W'(VALUE_W);
    else it.bit_count = COUNT_W'($urandom_range(1, VALUE_W));
    return it;
  endfunction

  // Returns at the rising edge of the transfer; in_push stays high so that
  // a following item can go out without a gap.
  task automatic send_item(input in_item_t item);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= item;
    while (!taken) begin
      @(posedge clk);
      if (!in_full) taken = 1'b1;
      else @(negedge clk);
    end
    stream_results_q.push_back(buffer_step(item));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (stream_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd32));
    send_item(make_cmd(CMD_WRITE, 32'h0000_0001, 6'd1));
    send_item(make_cmd(CMD_WRITE, 32'h5555_5555, 6'd31));
    send_item(make_cmd(CMD_WRITE, 32'hFFFA_BCDE, 6'd20));
    send_item(make_cmd(CMD_WRITE, 32'h1234_5678, 6'd32));
    send_item(make_cmd(CMD_WRITE, 32'h9ABC_DEF0, 6'd32));
    send_item(make_cmd(CMD_FLUSH, 32'hFFFF_FFFF, 6'd63));
    send_item(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd0));
    send_item(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd33));
    send_item(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd63));
    send_item(make_cmd(CMD_UNDEF, 32'hFFFF_FFFF, 6'd16));
    // A flush with nothing assembled still stores a zero word.
    send_item(make_cmd(CMD_FLUSH, 32'h0000_0000, 6'd0));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd32));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd1));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd31));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd20));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd32));
    send_item(make_cmd(CMD_READ, 32'h0000_0000, 6'd32));
    send_item(make_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd0));
    send_item(make_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd63));
    send_item(make_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd33));
    // These read on into the zero word and do not reach an empty store.
    repeat (3) send_item(make_cmd(CMD_READ, 32'hFFFF_FFFF, 6'd32));
    wait_results_drained();
  endtask

  task automatic test_store_full();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (STORE_WORDS + 2) send_item(make_cmd(CMD_FLUSH, $urandom, 6'd0));
    send_item(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd20));
    send_item(make_cmd(CMD_WRITE, 32'hA5A5_A5A5, 6'd32));
    send_item(make_cmd(CMD_WRITE, 32'h5A5A_5A5A, 6'd32));
    send_item(make_cmd(CMD_FLUSH, 32'h0000_0000, 6'd1));
    repeat (2 * STORE_WORDS + 12) send_item(make_cmd(CMD_READ, $urandom, 6'd32));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int items, input int send_pct,
                                     input int recv_pct, input int write_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (items) send_item(random_cmd(write_pct));
    wait_results_drained();
  endtask

  // The output side holds off long enough for the block to fill and stall
  // its input while items keep being offered.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pop_hold_req = 300;
    repeat (40) send_item(random_cmd(50));
    wait_results_drained();
  endtask

  always @(negedge clk) begin
    if (pop_hold_req != 0) begin
      pop_hold_left = pop_hold_req;
      pop_hold_req = 0;
    end
    if (pop_hold_left != 0) begin
      pop_hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (stream_results_q.size() == 0) begin
        $display("%0t: unexpected result read_value %h status %0d", $time,
                 out_item.read_value, out_item.status);
        error_count++;
      end else begin
        oldest_result = stream_results_q.pop_front();
        if (out_item.read_value !== oldest_result.read_value) begin
          $display("%0t: read_value expected %h got %h", $time,
                   oldest_result.read_value, out_item.read_value);
          error_count++;
        end
        if (out_item.status !== oldest_result.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   oldest_result.status, out_item.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               stream_results_q.size());
      $display("bit_granular_stream_buffer_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pop_hold_req = 0;
    pop_hold_left = 0;
    asm_word = '0;
    asm_fill = 0;
    drain_word = '0;
    drain_left = 0;
    mem_head = 0;
    mem_tail = 0;
    mem_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_store_full();
    test_random_traffic(330, 0, 0, 50);
    test_random_traffic(330, 76, 0, 75);
    test_random_traffic(330, 0, 76, 25);
    test_backpressure();
    test_random_traffic(330, 7, 7, 55);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && stream_results_q.size() == 0) begin
      $display("bit_granular_stream_buffer_core_tb OK");
    end else begin
      $display("bit_granular_stream_buffer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
